/* rtl/count_smaller_seen_values_defines.svh */
// Assertion macros for the count_smaller_seen_values block.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef COUNT_SMALLER_SEEN_VALUES_DEFINES_SVH
`define COUNT_SMALLER_SEEN_VALUES_DEFINES_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define CSV_CHECK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that cons holds in the cycle after ante holds.
`define CSV_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/csv_pkg.sv */
// Shared types and constants for the count_smaller_seen_values block.
// No dependencies; imported by every module of the block.
package csv_pkg;

	localparam int MAX_ITEMS  = 256;
	localparam int VALUE_BITS = 32;
	localparam int IDX_W      = $clog2(MAX_ITEMS);
	localparam int FILL_W     = $clog2(MAX_ITEMS + 1);
	localparam int CNT_W      = 9;

	typedef logic [VALUE_BITS-1:0] key_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [FILL_W-1:0]     fill_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	// Input and result items as seen on the ports.
	typedef struct packed {
		logic signed [31:0] value;
		logic               start_req;
	} in_item_t;

	typedef struct packed {
		logic [8:0] smaller_count;
		logic       capacity_exceeded;
	} out_item_t;

	// Token that walks down the cell chain with one item.
	typedef struct packed {
		logic valid;
		key_t key;
		logic start;
		idx_t slot;
		logic full;
		cnt_t count;
	} csv_tok_t;

	// Status of the front end.
	typedef struct packed {
		fill_t fill;
	} csv_stat_t;

	// Offset-binary key so that an unsigned compare follows the signed order.
	function automatic key_t order_key(input logic signed [31:0] raw);
		logic [63:0] wide;
		key_t        sign;
		begin
			wide = {32'd0, raw};
			sign = key_t'(1) << (VALUE_BITS - 1);
			return key_t'(wide) ^ sign;
		end
	endfunction

endpackage

/* rtl/csv_cell.sv */
// One cell of the comparison chain: holds one stored value and its valid bit.
// Depends on csv_pkg.
module csv_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  csv_pkg::idx_t   idx,
	input  csv_pkg::csv_tok_t tok_in,
	output csv_pkg::csv_tok_t tok_out
);
	import csv_pkg::*;

	key_t     value_q;
	logic     valid_q;
	csv_tok_t tok_q;
	logic     hit;
	logic     store;
	cnt_t     cnt_next;

	// A start item treats the cell as empty before comparing.
	assign hit      = tok_in.valid && valid_q && !tok_in.start && (value_q < tok_in.key);
	assign store    = tok_in.valid && !tok_in.full && (tok_in.slot == idx);
	assign cnt_next = (hit && (tok_in.count != '1)) ? tok_in.count + cnt_t'(1) : tok_in.count;

	// Stored entry: cleared as a start item passes, written at the item's slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			if (store) begin
				valid_q <= 1'b1;
			end else if (tok_in.valid && tok_in.start) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && store) begin
			value_q <= tok_in.key;
		end
	end

	// Token register handed to the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (adv) begin
			tok_q.valid <= tok_in.valid;
			tok_q.key   <= tok_in.key;
			tok_q.start <= tok_in.start;
			tok_q.slot  <= tok_in.slot;
			tok_q.full  <= tok_in.full;
			tok_q.count <= cnt_next;
		end
	end

	assign tok_out = tok_q;

endmodule

/* rtl/csv_feed.sv */
// Front end of the chain: keeps the fill count and builds the token for each item.
// Depends on csv_pkg.
module csv_feed (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  csv_pkg::in_item_t item,
	output csv_pkg::csv_tok_t tok,
	output csv_pkg::csv_stat_t stat
);
	import csv_pkg::*;

	fill_t fill_q;
	fill_t fill_base;
	logic  full;

	// A start item sees an empty set.
	assign fill_base = item.start_req ? '0 : fill_q;
	assign full      = (fill_base == fill_t'(MAX_ITEMS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (take) begin
			fill_q <= full ? fill_base : fill_base + fill_t'(1);
		end
	end

	// Token entering cell 0.
	always_comb begin
		tok.valid = take;
		tok.key   = order_key(item.value);
		tok.start = item.start_req;
		tok.slot  = fill_base[IDX_W-1:0];
		tok.full  = full;
		tok.count = '0;
	end

	assign stat.fill = fill_q;

endmodule

/* rtl/count_smaller_seen_values.sv */
// Top level of the count_smaller_seen_values block: front end, cell chain, result register.
// Depends on csv_pkg, csv_feed, csv_cell and count_smaller_seen_values_defines.svh.
//
// Usage: the host sends a sequence last element first over the in channel, with
// start_req set on the first item of each sequence. For each item one result
// comes out on the out channel: how many values stored since the last start are
// strictly smaller, and a flag when the set already held MAX_ITEMS values so the
// value was not stored.
// Each item walks a row of MAX_ITEMS cells, one cell per cycle while the chain
// advances; every cell holds one stored value and compares it as the item passes.
// Each cell registers the token for the next; the result register follows the last.
// Items may enter in every cycle, so throughput is one item per cycle while the
// chain is not stalled; later items see the stores of earlier ones as they trail them.
// Reset empties the set and the chain. When the receiver stalls with a result
// waiting, the whole chain and the input hold until that result is taken.
module count_smaller_seen_values (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  csv_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output csv_pkg::out_item_t out_item
);
	import csv_pkg::*;

	logic      adv;
	logic      take;
	csv_tok_t  chain [0:MAX_ITEMS];
	csv_stat_t stat;
	logic      out_valid_q;
	out_item_t out_item_q;

	// The chain moves whenever the result register is free or being emptied.
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;
	assign take     = in_valid && adv;

	csv_feed u_feed (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (in_item),
		.tok    (chain[0]),
		.stat   (stat)
	);

	// Row of comparison cells.
	for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
		csv_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.idx     (IDX_W'(g)),
			.tok_in  (chain[g]),
			.tok_out (chain[g+1])
		);
	end

	// Result register at the end of the chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= chain[MAX_ITEMS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_item_q.smaller_count     <= 9'(chain[MAX_ITEMS].count);
			out_item_q.capacity_exceeded <= chain[MAX_ITEMS].full;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	`include "count_smaller_seen_values_defines.svh"

	`CSV_CHECK_NOW(a_count_bound, out_valid, {23'd0, out_item.smaller_count} <= 32'(MAX_ITEMS), "count above capacity")
	`CSV_CHECK_NOW(a_fill_bound, 1'b1, {{(32-FILL_W){1'b0}}, stat.fill} <= 32'(MAX_ITEMS), "fill count above capacity")
	`CSV_CHECK_NEXT(a_start_fill, take && in_item.start_req, stat.fill == fill_t'(1), "start item did not restart fill")
	`CSV_CHECK_NEXT(a_full_hold, take && !in_item.start_req && (stat.fill == fill_t'(MAX_ITEMS)), stat.fill == fill_t'(MAX_ITEMS), "full set changed size")

endmodule
